@@ rtl/text_encoding_autodetect_defines.svh @@
// ---------------------------------------------------------------------------
// Text encoding autodetect assertion macros
// Concurrent assertion shorthands used by the top-level RTL of the detector.
// ---------------------------------------------------------------------------
`ifndef TEXT_ENCODING_AUTODETECT_DEFINES_SVH
`define TEXT_ENCODING_AUTODETECT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define TEA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define TEA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define TEA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TEA_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/tea_pkg.sv @@
// ---------------------------------------------------------------------------
// Text encoding autodetect package
// Shared types and constants of the encoding detector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tea_pkg;

  // Bytes in one aligned detection block.
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned BlockPosW  = $clog2(BlockBytes);

  localparam logic [7:0] SurrTag      = 8'hD8;
  localparam logic [7:0] SurrMask     = 8'hF8;
  localparam logic [7:0] HalfMask     = 8'hFC;
  localparam logic [7:0] HighSurrTag  = 8'hD8;
  localparam logic [7:0] LowSurrTag   = 8'hDC;
  localparam logic [23:0] MaxCodePt   = 24'h10FFFF;

  // Range rule for the first continuation byte of a UTF-8 sequence.
  typedef enum logic [2:0] {
    RULE_NONE  = 3'd0,
    RULE_A0_BF = 3'd1,
    RULE_80_9F = 3'd2,
    RULE_90_BF = 3'd3,
    RULE_80_8F = 3'd4
  } u8_rule_e;

  // One byte step broadcast to every validator.
  typedef struct packed {
    logic       en;
    logic       last;
    logic [7:0] data;
  } step_t;

endpackage

@@ rtl/tea_utf8.sv @@
// ---------------------------------------------------------------------------
// UTF-8 validator
// Tracks open multi-byte sequences with overlong, surrogate and range rules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tea_utf8 (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tea_pkg::step_t step_i,
  output logic           ok_o
);
  import tea_pkg::*;

  logic [1:0] pending_q, pending_d;
  u8_rule_e   rule_q, rule_d;
  logic       failed_q, failed_d;
  logic [7:0] lo, hi, b;

  assign b = step_i.data;

  always_comb begin
    lo = 8'h80;
    hi = 8'hBF;
    unique case (rule_q)
      RULE_A0_BF: lo = 8'hA0;
      RULE_80_9F: hi = 8'h9F;
      RULE_90_BF: lo = 8'h90;
      RULE_80_8F: hi = 8'h8F;
      default: ;
    endcase
  end

  always_comb begin
    pending_d = pending_q;
    rule_d    = RULE_NONE;
    failed_d  = failed_q;
    if (pending_q != 2'd0) begin
      if (b < lo || b > hi) failed_d = 1'b1;
      pending_d = pending_q - 2'd1;
    end else if (b < 8'h80) begin
      pending_d = 2'd0;
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      pending_d = 2'd1;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      pending_d = 2'd2;
      if (b == 8'hE0) rule_d = RULE_A0_BF;
      else if (b == 8'hED) rule_d = RULE_80_9F;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      pending_d = 2'd3;
      if (b == 8'hF0) rule_d = RULE_90_BF;
      else if (b == 8'hF4) rule_d = RULE_80_8F;
    end else begin
      failed_d = 1'b1;
    end
  end

  assign ok_o = !failed_d && (pending_d == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
      rule_q    <= RULE_NONE;
      failed_q  <= 1'b0;
    end else if (step_i.en) begin
      if (step_i.last) begin
        pending_q <= 2'd0;
        rule_q    <= RULE_NONE;
        failed_q  <= 1'b0;
      end else begin
        pending_q <= pending_d;
        rule_q    <= rule_d;
        failed_q  <= failed_d;
      end
    end
  end

endmodule

@@ rtl/tea_utf16.sv @@
// ---------------------------------------------------------------------------
// UTF-16LE validator
// Assembles 16-bit units and checks surrogate pairing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tea_utf16 (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tea_pkg::step_t step_i,
  output logic           ok_o
);
  import tea_pkg::*;

  logic phase_q, phase_d;
  logic want_q, want_d;
  logic failed_q, failed_d;
  logic is_high, is_low;

  // Only the upper byte of a unit decides whether it is a surrogate.
  assign is_high = (step_i.data & HalfMask) == HighSurrTag;
  assign is_low  = (step_i.data & HalfMask) == LowSurrTag;

  always_comb begin
    phase_d  = ~phase_q;
    want_d   = want_q;
    failed_d = failed_q;
    if (phase_q) begin
      if (want_q) begin
        if (!is_low) failed_d = 1'b1;
        want_d = 1'b0;
      end else if (is_high) begin
        want_d = 1'b1;
      end else if (is_low) begin
        failed_d = 1'b1;
      end
    end
  end

  assign ok_o = !failed_d && !want_d && !phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 1'b0;
      want_q   <= 1'b0;
      failed_q <= 1'b0;
    end else if (step_i.en) begin
      if (step_i.last) begin
        phase_q  <= 1'b0;
        want_q   <= 1'b0;
        failed_q <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        want_q   <= want_d;
        failed_q <= failed_d;
      end
    end
  end

endmodule

@@ rtl/tea_utf32.sv @@
// ---------------------------------------------------------------------------
// UTF-32LE validator
// Assembles 32-bit words and checks range and surrogate exclusion.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tea_utf32 (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tea_pkg::step_t step_i,
  output logic           ok_o
);
  import tea_pkg::*;

  logic [1:0]  phase_q, phase_d;
  logic [23:0] partial_q, partial_d;
  logic        failed_q, failed_d;
  logic        bad_word;

  // The word is bad if above the code point limit or a surrogate.
  assign bad_word = (step_i.data != 8'h00) || (partial_q > MaxCodePt) ||
                    ((partial_q[23:16] == 8'h00) && (partial_q[15:11] == 5'b11011));

  always_comb begin
    phase_d   = phase_q + 2'd1;
    partial_d = partial_q;
    failed_d  = failed_q;
    case (phase_q)
      2'd0: partial_d[7:0]   = step_i.data;
      2'd1: partial_d[15:8]  = step_i.data;
      2'd2: partial_d[23:16] = step_i.data;
      default: begin
        if (bad_word) failed_d = 1'b1;
        partial_d = '0;
      end
    endcase
  end

  assign ok_o = !failed_d && (phase_d == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 2'd0;
      failed_q <= 1'b0;
    end else if (step_i.en) begin
      if (step_i.last) begin
        phase_q  <= 2'd0;
        failed_q <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        failed_q <= failed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.en) begin
      partial_q <= step_i.last ? '0 : partial_d;
    end
  end

endmodule

@@ rtl/tea_block.sv @@
// ---------------------------------------------------------------------------
// Surrogate block tracker
// Cuts the buffer into aligned blocks and latches surrogate mode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tea_block (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tea_pkg::step_t step_i,
  output logic           mode_o
);
  import tea_pkg::*;

  logic [BlockPosW-1:0] pos_q, pos_d;
  logic                 has_q, has_d;
  logic                 mode_q, mode_d;
  logic                 seen;

  // A surrogate high byte sits at an odd offset in little-endian order.
  assign seen = pos_q[0] && ((step_i.data & SurrMask) == SurrTag);

  always_comb begin
    pos_d  = pos_q + BlockPosW'(1);
    has_d  = has_q | seen;
    mode_d = mode_q;
    if (pos_q == BlockPosW'(BlockBytes - 1)) begin
      mode_d = mode_q | has_d;
      has_d  = 1'b0;
    end
  end

  assign mode_o = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      has_q  <= 1'b0;
      mode_q <= 1'b0;
    end else if (step_i.en) begin
      if (step_i.last) begin
        pos_q  <= '0;
        has_q  <= 1'b0;
        mode_q <= 1'b0;
      end else begin
        pos_q  <= pos_d;
        has_q  <= has_d;
        mode_q <= mode_d;
      end
    end
  end

endmodule

@@ rtl/text_encoding_autodetect.sv @@
// ---------------------------------------------------------------------------
// Text encoding autodetect
// Judges a byte buffer as UTF-8, UTF-16LE and UTF-32LE in one pass.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Content
//  s_axis    in         tdata[7:0] data_byte, tlast last_byte
//  m_axis    out        tdata[3:0] utf8_valid, utf16le_valid, utf32le_valid,
//                       unspecified (from bit 0 up), tdata[7:4] zero
//
// One byte is taken in every cycle while no last byte is held in the input
// register. A byte waits there and updates the validators as it leaves it;
// a last byte also loads the result register. Reset clears all validator
// state except the UTF-32LE partial word; the state also returns to reset
// after every last byte, so buffers follow each other without a gap.
// Only a last byte waits on a stalled result register; other bytes flow on.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_encoding_autodetect (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // last_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [0] utf8_valid, [1] utf16le_valid,
                                       // [2] utf32le_valid, [3] unspecified
);
  import tea_pkg::*;

`include "text_encoding_autodetect_defines.svh"

  // Input register.
  logic       in_valid_q;
  logic       in_last_q;
  logic [7:0] in_data_q;

  // Result register.
  logic       out_valid_q;
  logic [3:0] out_flags_q, out_flags_d;

  logic  advance;
  logic  out_load;
  step_t step;
  logic  ok8, ok16, ok32, mode;

  // A byte leaves the input register unless it is a last byte and the
  // result register still holds an unread verdict.
  assign advance  = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign out_load = advance && in_last_q;
  assign s_axis_tready_o = !in_valid_q || advance;

  assign step.en   = advance;
  assign step.last = in_last_q;
  assign step.data = in_data_q;

  tea_utf8 u_utf8 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ok_o   (ok8)
  );

  tea_utf16 u_utf16 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ok_o   (ok16)
  );

  tea_utf32 u_utf32 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ok_o   (ok32)
  );

  tea_block u_block (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .mode_o (mode)
  );

  // In surrogate mode only the UTF-16LE verdict counts, and a failing one is
  // reported as unspecified.
  always_comb begin
    if (mode) begin
      out_flags_d = {!ok16, 1'b0, ok16, 1'b0};
    end else begin
      out_flags_d = {1'b0, ok32, ok16, ok8};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_flags_q <= out_flags_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_flags_q};

  // Unspecified excludes every positive verdict.
  `TEA_ASSERT_IMP(a_unspec_alone, clk_i, rst_ni, out_valid_q && out_flags_q[3], out_flags_q[2:0] == 3'b000)

  // The input side only stalls while a byte is held.
  `TEA_ASSERT_IMP(a_stall_held, clk_i, rst_ni, !s_axis_tready_o, in_valid_q && in_last_q && out_valid_q)

  // A taken verdict with no new last byte behind it leaves the output empty.
  `TEA_ASSERT_NXT(a_out_drain, clk_i, rst_ni, out_valid_q && m_axis_tready_i && !out_load, !out_valid_q)

endmodule

@@ test/tb_text_encoding_autodetect.sv @@
// ---------------------------------------------------------------------------
// Testbench for the text encoding autodetector
// Streams byte buffers into the detector. Each verdict that comes back is
// compared flag by flag with a typed-in verdict or with a behavioural model
// that runs in the bench. A short table of hand-made buffers comes first.
// Random UTF-8, UTF-16LE and UTF-32LE buffers, noise and damaged buffers
// follow, with idle cycles on the input side and stalls on the output side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_encoding_autodetect;
  import tea_pkg::*;

  localparam int RandomItems = 1850;
  localparam int HoldOffFrom = 800;
  localparam int HoldOffTo   = 1200;

  // Packed so that bit 0 lines up with tdata bit 0 of the result port.
  typedef struct packed {
    logic unspecified;
    logic utf32le;
    logic utf16le;
    logic utf8;
  } verdict_t;

  // One row of the hand-made table. Where pinned is set, the verdict is typed
  // in; otherwise it comes from the model.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       pinned;
    verdict_t   want;
  } table_row_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       pinned;
    verdict_t   want;
    logic       hold;    // wait for every outstanding verdict before this item
  } byte_item_t;

  localparam int TableRows = 26;
  localparam table_row_t BYTE_TABLE [TableRows] = '{
    //  byte   last  pinned  {unspec, u32, u16, u8}
    '{8'h00, 1'b1, 1'b1, 4'b0001},   // single byte: odd length
    '{8'hFF, 1'b1, 1'b1, 4'b0000},   // single illegal byte
    '{8'h00, 1'b0, 1'b0, 4'b0000},
    '{8'h00, 1'b1, 1'b1, 4'b0011},   // one 16-bit unit, too short for UTF-32
    '{8'hFF, 1'b0, 1'b0, 4'b0000},
    '{8'hFF, 1'b0, 1'b0, 4'b0000},
    '{8'h10, 1'b0, 1'b0, 4'b0000},
    '{8'h00, 1'b1, 1'b1, 4'b0110},   // word 0x10FFFF, the top code point
    '{8'h00, 1'b0, 1'b0, 4'b0000},
    '{8'h00, 1'b0, 1'b0, 4'b0000},
    '{8'h11, 1'b0, 1'b0, 4'b0000},
    '{8'h00, 1'b1, 1'b1, 4'b0011},   // word 0x110000, just beyond the range
    '{8'h00, 1'b0, 1'b0, 4'b0000},
    '{8'hD8, 1'b1, 1'b1, 4'b0000},   // high surrogate and UTF-8 lead left open
    '{8'h3D, 1'b0, 1'b0, 4'b0000},   // surrogate pair D83D DC00
    '{8'hD8, 1'b0, 1'b0, 4'b0000},
    '{8'h00, 1'b0, 1'b0, 4'b0000},
    '{8'hDC, 1'b1, 1'b0, 4'b0000},
    '{8'hE0, 1'b0, 1'b0, 4'b0000},   // overlong three-byte UTF-8
    '{8'h80, 1'b0, 1'b0, 4'b0000},
    '{8'h80, 1'b0, 1'b0, 4'b0000},
    '{8'h00, 1'b1, 1'b0, 4'b0000},
    '{8'hF0, 1'b0, 1'b0, 4'b0000},   // U+10000 in four UTF-8 bytes
    '{8'h90, 1'b0, 1'b0, 4'b0000},
    '{8'h80, 1'b0, 1'b0, 4'b0000},
    '{8'h80, 1'b1, 1'b0, 4'b0000}
  };

  string verdict_field [4] = '{"utf8_valid", "utf16le_valid", "utf32le_valid",
                               "unspecified"};

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  byte_item_t byte_plan [$];
  logic [7:0] scratch [$];
  verdict_t   verdicts_due [$];
  int         bad_results = 0;

  // Model state: UTF-8 sequence tracking.
  logic [1:0]  mb_due;
  u8_rule_e    mb_rule;
  logic        mb_bad;
  // UTF-16LE unit assembly and surrogate pairing.
  logic        w16_odd;
  logic [7:0]  w16_lo;
  logic        w16_need_low;
  logic        w16_bad;
  // UTF-32LE word assembly.
  logic [1:0]  w32_count;
  logic [23:0] w32_acc;
  logic        w32_bad;
  // Aligned 64-byte block tracking for the surrogate scan.
  logic [5:0]  blk_pos;
  logic        blk_surr;
  logic        surr_only;

  text_encoding_autodetect uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #6 clk = ~clk;

  initial begin
    #6_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Appends one byte to the buffer under construction.
  function automatic void stash_byte(input logic [7:0] b);
    scratch = {scratch, b};
  endfunction

  // Appends one item to the send plan.
  function automatic void plan_item(input byte_item_t item);
    byte_plan = {byte_plan, item};
  endfunction

  // Appends one verdict to those still awaited from the detector.
  function automatic void expect_verdict(input verdict_t v);
    verdicts_due = {verdicts_due, v};
  endfunction

  function automatic void clear_detector();
    mb_due = 2'd0; mb_rule = RULE_NONE; mb_bad = 1'b0;
    w16_odd = 1'b0; w16_lo = 8'h00; w16_need_low = 1'b0; w16_bad = 1'b0;
    w32_count = 2'd0; w32_acc = 24'h0; w32_bad = 1'b0;
    blk_pos = 6'd0; blk_surr = 1'b0; surr_only = 1'b0;
  endfunction

  // Advances the model by one byte. Returns 1 when the byte closes a buffer,
  // with the verdict in v.
  function automatic bit detect_byte(input logic [7:0] b, input logic last,
                                     output verdict_t v);
    logic [7:0]  lo, hi;
    logic [15:0] unit;
    logic [31:0] word;
    logic        is_high, is_low, ok8, ok16, ok32;

    v = '0;
    // A surrogate high byte sits in the odd byte of a 16-bit unit.
    if (blk_pos[0] && (b & 8'hF8) == 8'hD8) blk_surr = 1'b1;
    if (blk_pos == 6'd63) begin
      if (blk_surr) surr_only = 1'b1;
      blk_surr = 1'b0;
    end
    blk_pos = blk_pos + 6'd1;

    if (mb_due != 2'd0) begin
      lo = 8'h80;
      hi = 8'hBF;
      case (mb_rule)
        RULE_A0_BF: lo = 8'hA0;
        RULE_80_9F: hi = 8'h9F;
        RULE_90_BF: lo = 8'h90;
        RULE_80_8F: hi = 8'h8F;
        default: ;
      endcase
      if (b < lo || b > hi) mb_bad = 1'b1;
      mb_rule = RULE_NONE;
      mb_due  = mb_due - 2'd1;
    end else begin
      mb_rule = RULE_NONE;
      if (b < 8'h80) begin
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        mb_due = 2'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        mb_due = 2'd2;
        if (b == 8'hE0) mb_rule = RULE_A0_BF;
        else if (b == 8'hED) mb_rule = RULE_80_9F;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        mb_due = 2'd3;
        if (b == 8'hF0) mb_rule = RULE_90_BF;
        else if (b == 8'hF4) mb_rule = RULE_80_8F;
      end else begin
        mb_bad = 1'b1;
      end
    end

    if (!w16_odd) begin
      w16_lo  = b;
      w16_odd = 1'b1;
    end else begin
      w16_odd = 1'b0;
      unit    = {b, w16_lo};
      is_high = unit >= 16'hD800 && unit <= 16'hDBFF;
      is_low  = unit >= 16'hDC00 && unit <= 16'hDFFF;
      if (w16_need_low) begin
        if (!is_low) w16_bad = 1'b1;
        w16_need_low = 1'b0;
      end else if (is_high) begin
        w16_need_low = 1'b1;
      end else if (is_low) begin
        w16_bad = 1'b1;
      end
    end

    if (w32_count != 2'd3) begin
      w32_acc   = w32_acc | (24'(b) << (8 * w32_count));
      w32_count = w32_count + 2'd1;
    end else begin
      word = {b, w32_acc};
      if (word > 32'h10FFFF || (word >= 32'hD800 && word <= 32'hDFFF)) w32_bad = 1'b1;
      w32_count = 2'd0;
      w32_acc   = 24'h0;
    end

    if (!last) return 1'b0;

    ok8  = !mb_bad && mb_due == 2'd0;
    ok16 = !w16_bad && !w16_need_low && !w16_odd;
    ok32 = !w32_bad && w32_count == 2'd0;
    v.utf16le = ok16;
    if (surr_only) begin
      v.unspecified = !ok16;
    end else begin
      v.utf8    = ok8;
      v.utf32le = ok32;
    end
    clear_detector();
    return 1'b1;
  endfunction

  function automatic logic [31:0] any_code_point();
    logic [31:0] corner [10];
    logic [31:0] cp;

    corner = '{32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hD7FF, 32'hE000,
               32'hFFFF, 32'h10000, 32'h10FFFF};
    case ($urandom_range(0, 7))
      0, 1: cp = $urandom_range(0, 'h7F);
      2: cp = $urandom_range('h80, 'h7FF);
      3: begin
        // Skip the surrogate range by shifting the top of the draw upwards.
        cp = $urandom_range('h800, 'hF7FF);
        if (cp >= 'hD800) cp = cp + 'h800;
      end
      4, 5: cp = $urandom_range('h10000, 'h10FFFF);
      default: cp = corner[$urandom_range(0, 9)];
    endcase
    return cp;
  endfunction

  function automatic void put_utf8(input logic [31:0] cp);
    if (cp < 'h80) begin
      stash_byte(cp[7:0]);
    end else if (cp < 'h800) begin
      stash_byte({3'b110, cp[10:6]});
      stash_byte({2'b10, cp[5:0]});
    end else if (cp < 'h10000) begin
      stash_byte({4'b1110, cp[15:12]});
      stash_byte({2'b10, cp[11:6]});
      stash_byte({2'b10, cp[5:0]});
    end else begin
      stash_byte({5'b11110, cp[20:18]});
      stash_byte({2'b10, cp[17:12]});
      stash_byte({2'b10, cp[11:6]});
      stash_byte({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void put_utf16(input logic [31:0] cp);
    logic [31:0] offs;
    logic [15:0] hi_unit, lo_unit;

    if (cp < 'h10000) begin
      stash_byte(cp[7:0]);
      stash_byte(cp[15:8]);
    end else begin
      offs    = cp - 'h10000;
      hi_unit = 16'hD800 | 16'(offs[19:10]);
      lo_unit = 16'hDC00 | 16'(offs[9:0]);
      stash_byte(hi_unit[7:0]);
      stash_byte(hi_unit[15:8]);
      stash_byte(lo_unit[7:0]);
      stash_byte(lo_unit[15:8]);
    end
  endfunction

  function automatic void put_word32(input logic [31:0] w);
    for (int i = 0; i < 4; i++) stash_byte(w[8*i +: 8]);
  endfunction

  // Mostly short buffers; some fill exactly one or two blocks, some leave a
  // partial block behind one or two full ones.
  function automatic int pick_length();
    int r;

    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 24);
    if (r < 8) return $urandom_range(25, 63);
    if (r == 8) return $urandom_range(0, 1) ? 64 : 128;
    return $urandom_range(65, 140);
  endfunction

  function automatic void fill_buffer();
    int          len, r;
    logic [31:0] cp;

    scratch.delete();
    len = pick_length();
    r   = $urandom_range(0, 9);
    if (r < 3) begin
      while (scratch.size() < len) put_utf8(any_code_point());
    end else if (r < 6) begin
      len = (len < 2) ? 2 : len & ~1;
      while (scratch.size() < len) begin
        cp = any_code_point();
        if (cp >= 'h10000 && len - scratch.size() < 4) cp = $urandom_range(0, 'hD7FF);
        put_utf16(cp);
      end
    end else if (r < 8) begin
      len = (len < 4) ? 4 : len & ~3;
      while (scratch.size() < len) begin
        case ($urandom_range(0, 15))
          0: put_word32($urandom());
          1: put_word32($urandom_range('hD800, 'hDFFF));
          2: put_word32(32'h110000);
          default: put_word32(any_code_point());
        endcase
      end
    end else begin
      repeat (len) stash_byte(8'($urandom_range(0, 255)));
    end

    // A share of the buffers is damaged after the fact.
    case ($urandom_range(0, 19))
      0, 1, 2, 3: scratch[$urandom_range(0, scratch.size() - 1)] = 8'($urandom_range(0, 255));
      4: if (scratch.size() > 1) void'(scratch.pop_back());
      5: stash_byte(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endfunction

  function automatic void queue_buffer(input logic hold);
    byte_item_t item;

    foreach (scratch[i]) begin
      item.data   = scratch[i];
      item.last   = (i == scratch.size() - 1);
      item.pinned = 1'b0;
      item.want   = '0;
      item.hold   = hold && i == 0;
      plan_item(item);
    end
  endfunction

  // Output side: a changing stall pattern, and one long hold-off so that a
  // last byte backs up into the input while the sender keeps offering items.
  initial begin : result_sink
    int cycle_no, mode, mode_left;

    cycle_no  = 0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (cycle_no >= HoldOffFrom && cycle_no < HoldOffTo) begin
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (cycle_no % 4 == 0);
          default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : verdict_check
    verdict_t   want;
    logic [3:0] want_bits;

    if (rst_n && m_tvalid && m_tready) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict with none outstanding: tdata %02h", m_tdata);
        bad_results++;
      end else begin
        want      = verdicts_due.pop_front();
        want_bits = want;
        for (int i = 0; i < 4; i++) begin
          if (m_tdata[i] !== want_bits[i]) begin
            $error("%s: expected %0d, actual %0d", verdict_field[i], want_bits[i], m_tdata[i]);
            bad_results++;
          end
        end
        if (m_tdata[7:4] !== 4'h0) begin
          $error("tdata padding: expected 0, actual %0h", m_tdata[7:4]);
          bad_results++;
        end
      end
    end
  end

  initial begin : byte_source
    byte_item_t item;
    verdict_t   v;
    int         target, burst_left;
    logic       mid_hold_done;

    clear_detector();
    foreach (BYTE_TABLE[i]) begin
      item.data   = BYTE_TABLE[i].data;
      item.last   = BYTE_TABLE[i].last;
      item.pinned = BYTE_TABLE[i].pinned;
      item.want   = BYTE_TABLE[i].want;
      item.hold   = 1'b0;
      plan_item(item);
    end
    // The random part opens with a full drain, and drains once more halfway.
    target        = byte_plan.size() + RandomItems;
    mid_hold_done = 1'b0;
    fill_buffer();
    queue_buffer(1'b1);
    while (byte_plan.size() < target) begin
      fill_buffer();
      queue_buffer(!mid_hold_done && byte_plan.size() > target - RandomItems / 2);
      if (byte_plan.size() > target - RandomItems / 2) mid_hold_done = 1'b1;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_left = 0;
    while (byte_plan.size() != 0) begin
      item = byte_plan.pop_front();
      if (!s_tvalid) begin
        if (item.hold) begin
          while (verdicts_due.size() != 0) @(posedge clk);
        end
        if (burst_left == 0) begin
          repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5))
            @(posedge clk);
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 16);
        end
      end
      s_tvalid <= 1'b1;
      s_tdata  <= item.data;
      s_tlast  <= item.last;
      do @(posedge clk); while (!s_tready);
      if (detect_byte(item.data, item.last, v)) begin
        expect_verdict(item.pinned ? item.want : v);
      end
      burst_left--;
      // Drop valid between items unless the next item follows at once.
      if (burst_left <= 0 || byte_plan.size() == 0 || byte_plan[0].hold) begin
        burst_left = (burst_left < 0) ? 0 : burst_left;
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end

    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_results == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tea_pkg.sv
rtl/tea_utf8.sv
rtl/tea_utf16.sv
rtl/tea_utf32.sv
rtl/tea_block.sv
rtl/text_encoding_autodetect.sv
test/tb_text_encoding_autodetect.sv
